### rtl/tbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbp_pkg
// shared constants, types and counter helper for the tournament predictor
// ----------------------------------------------------------------------------
package tbp_pkg;

    localparam int ADDR_WIDTH = 64;
    localparam int SLOTS      = 1024;             // power of two
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CTR_W      = 2;

    // 2-bit counter codes
    localparam logic [CTR_W-1:0] CTR_MIN    = 2'd0;
    localparam logic [CTR_W-1:0] CTR_WEAK_N = 2'd1;
    localparam logic [CTR_W-1:0] CTR_WEAK_T = 2'd2;
    localparam logic [CTR_W-1:0] CTR_MAX    = 2'd3;

    // predictor_mode codes, the unused code behaves as tournament
    localparam logic [1:0] MODE_LOCAL  = 2'd0;
    localparam logic [1:0] MODE_GLOBAL = 2'd1;
    localparam logic [1:0] MODE_TOURN  = 2'd2;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] tag;
        logic [CTR_W-1:0]      ctr;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        t_entry            entry;
    } t_wr_req;

    // saturating step of a 2-bit counter
    function automatic logic [CTR_W-1:0] sat_move(input logic [CTR_W-1:0] c,
                                                  input logic up);
        logic [CTR_W-1:0] r;
        if (up) begin
            r = (c == CTR_MAX) ? CTR_MAX : c + CTR_W'(1);
        end else begin
            r = (c == CTR_MIN) ? CTR_MIN : c - CTR_W'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/tbp_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbp_table
// local tag and counter memory with clearing sweep and write forwarding
// ----------------------------------------------------------------------------
module tbp_table (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic [tbp_pkg::SLOT_W-1:0] i_rd_slot,
    output tbp_pkg::t_entry                 o_rd_entry,
    input  tbp_pkg::t_wr_req                i_wr,
    output logic                            o_clearing
);
    import tbp_pkg::*;

    t_entry            mem [SLOTS];
    t_entry            r_rd_data;
    logic [SLOT_W-1:0] r_rd_slot;
    logic              r_fwd_vld;
    logic [SLOT_W-1:0] r_fwd_slot;
    t_entry            r_fwd_entry;
    logic              r_clr_busy;
    logic [SLOT_W-1:0] r_clr_idx;
    logic              n_clr_busy;
    logic [SLOT_W-1:0] n_clr_idx;
    t_wr_req           wr;

    // clearing sweep owns the write port until done
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_idx  = r_clr_idx;
        if (r_clr_busy) begin
            n_clr_idx = r_clr_idx + SLOT_W'(1);
            if (r_clr_idx == SLOT_W'(SLOTS - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
        if (r_clr_busy) begin
            wr.en    = 1'b1;
            wr.slot  = r_clr_idx;
            wr.entry = '0;
        end else begin
            wr = i_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_fwd_vld  <= 1'b0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_idx  <= n_clr_idx;
            r_fwd_vld  <= i_wr.en && !r_clr_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_slot  <= i_wr.slot;
        r_fwd_entry <= i_wr.entry;
    end

    // memory: one write and one read port, read data registered
    always_ff @(posedge i_clk) begin
        if (wr.en) begin
            mem[wr.slot] <= wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_slot];
            r_rd_slot <= i_rd_slot;
        end
    end

    // a write in the same cycle as the read is not yet seen by the array
    assign o_rd_entry = (r_fwd_vld && (r_fwd_slot == r_rd_slot)) ? r_fwd_entry : r_rd_data;
    assign o_clearing = r_clr_busy;

endmodule
`default_nettype wire

### rtl/tournament_branch_predictor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// local, global and tournament prediction of resolved conditional branches
// ----------------------------------------------------------------------------
// one request per clock while busy is low: a request (branch address and the
// address that followed) is taken at each edge where start is high and busy
// is low, and its result passes the request stage and the output register to
// the o_ result ports, marked by o_result_valid for exactly one cycle. the
// receiver cannot stall, so results must be captured when the strobe is high.
// after reset busy stays high while the local table is swept to zero; after
// that busy stays low and a new request may be given every cycle. the rate is
// set by the local table memory: one read and one write per cycle, with a
// write forwarded to a read of the same slot issued in the same cycle.
// predictor_mode may be written at any time the block holds no request.
// ----------------------------------------------------------------------------
module tournament_branch_predictor (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request side
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [tbp_pkg::ADDR_WIDTH-1:0] i_branch_pc,
    input  wire logic [tbp_pkg::ADDR_WIDTH-1:0] i_next_pc,
    // configuration
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [1:0]                     i_cfg_wr_data,
    // results
    output logic                                o_result_valid,
    output logic                                o_predicted_taken,
    output logic                                o_actual_taken,
    output logic                                o_prediction_correct
);
    import tbp_pkg::*;

    logic                  accept;
    logic [ADDR_WIDTH-1:0] pc_plus4;
    logic                  clearing;

    // mode register
    logic [1:0]            r_mode;

    // request stage, table read in flight
    logic                  r_s1_vld;
    logic [ADDR_WIDTH-1:0] r_s1_pc;
    logic                  r_s1_taken;

    // shared counters
    logic [CTR_W-1:0]      r_glob;
    logic [CTR_W-1:0]      r_chooser;
    logic [CTR_W-1:0]      n_glob;
    logic [CTR_W-1:0]      n_chooser;

    // evaluate stage
    t_entry                rd_entry;
    t_wr_req               wr_req;
    logic                  hit;
    logic                  lp;
    logic                  gp;
    logic                  tp;
    logic                  pred;

    // output register
    logic                  r_out_vld;
    logic                  r_out_pred;
    logic                  r_out_taken;
    logic                  r_out_corr;

    assign busy   = clearing;
    assign accept = start && !busy;

    // taken when the following address is not the fall-through, wrapping
    assign pc_plus4 = i_branch_pc + ADDR_WIDTH'(4);

    tbp_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_slot  (i_branch_pc[SLOT_W-1:0]),
        .o_rd_entry (rd_entry),
        .i_wr       (wr_req),
        .o_clearing (clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TOURN;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pc    <= i_branch_pc;
            r_s1_taken <= (i_next_pc != pc_plus4);
        end
    end

    // prediction from the state as it stood before this request
    always_comb begin
        hit  = (rd_entry.tag == r_s1_pc);
        lp   = hit && (rd_entry.ctr >= CTR_WEAK_T);
        gp   = (r_glob >= CTR_WEAK_T);
        // on disagreement the chooser's upper half favours global
        tp   = (lp == gp) ? lp : ((r_chooser >= CTR_WEAK_T) ? gp : lp);
        unique case (r_mode)
            MODE_LOCAL:  pred = lp;
            MODE_GLOBAL: pred = gp;
            default:     pred = tp;
        endcase
    end

    // training: every source learns on every request, whatever the mode
    always_comb begin
        wr_req.en        = r_s1_vld;
        wr_req.slot      = r_s1_pc[SLOT_W-1:0];
        wr_req.entry.tag = r_s1_pc;
        if (hit) begin
            wr_req.entry.ctr = sat_move(rd_entry.ctr, r_s1_taken);
        end else begin
            // miss: retag and seed weakly towards the outcome
            wr_req.entry.ctr = r_s1_taken ? CTR_WEAK_T : CTR_WEAK_N;
        end

        n_glob    = r_glob;
        n_chooser = r_chooser;
        if (r_s1_vld) begin
            n_glob = sat_move(r_glob, r_s1_taken);
            // chooser moves towards whichever source was right
            if (lp != gp) begin
                n_chooser = sat_move(r_chooser, gp == r_s1_taken);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glob    <= CTR_MIN;
            r_chooser <= CTR_MIN;
            r_out_vld <= 1'b0;
        end else begin
            r_glob    <= n_glob;
            r_chooser <= n_chooser;
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pred  <= pred;
        r_out_taken <= r_s1_taken;
        r_out_corr  <= (pred == r_s1_taken);
    end

    assign o_result_valid       = r_out_vld;
    assign o_predicted_taken    = r_out_pred;
    assign o_actual_taken       = r_out_taken;
    assign o_prediction_correct = r_out_corr;

endmodule
`default_nettype wire

### rtl/tbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbp_checker
// port-level checks on request timing and result consistency
// ----------------------------------------------------------------------------
module tbp_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_result_valid,
    input wire logic o_predicted_taken,
    input wire logic o_actual_taken,
    input wire logic o_prediction_correct
);

    // every request gives exactly one result, through the request and output registers
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_valid)
        else $error("request without result");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 2))
        else $error("result without request");

    // reset starts the clearing sweep
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

    // no result can come while the table is being cleared
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result during clearing");

    a_correct_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_prediction_correct == (o_predicted_taken == o_actual_taken)))
        else $error("correct flag mismatch");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .start                (start),
    .busy                 (busy),
    .o_result_valid       (o_result_valid),
    .o_predicted_taken    (o_predicted_taken),
    .o_actual_taken       (o_actual_taken),
    .o_prediction_correct (o_prediction_correct)
);
`default_nettype wire

### tb/tbp_outcome_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_outcome_checker
// watches the request, configuration and result ports of the predictor, keeps
// its own copy of the tables and counters, and checks every result strobe
// against the oldest predicted outcome
// ----------------------------------------------------------------------------
module tbp_outcome_checker
    import tbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [ADDR_WIDTH-1:0] i_branch_pc,
    input  logic [ADDR_WIDTH-1:0] i_next_pc,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_wr_data,
    input  logic                  i_result_valid,
    input  logic                  i_predicted_taken,
    input  logic                  i_actual_taken,
    input  logic                  i_prediction_correct,
    output int                    o_pending,
    output int                    o_errors
);

    typedef struct packed {
        logic predicted;
        logic actual;
        logic correct;
    } outcome_t;

    logic [ADDR_WIDTH-1:0] tag_mirror [SLOTS];
    logic [CTR_W-1:0]      local_mirror [SLOTS];
    logic [CTR_W-1:0]      global_mirror;
    logic [CTR_W-1:0]      chooser_mirror;
    logic [1:0]            mode_mirror;
    outcome_t              outcome_q [$];
    int                    mismatches = 0;

    // saturating 2-bit step
    function automatic logic [CTR_W-1:0] nudge(input logic [CTR_W-1:0] c, input logic up);
        if (up) begin
            return (c == CTR_MAX) ? CTR_MAX : c + 1'b1;
        end
        return (c == CTR_MIN) ? CTR_MIN : c - 1'b1;
    endfunction

    // forms the outcome from the state before this branch, then trains
    function automatic outcome_t resolve_branch(input logic [ADDR_WIDTH-1:0] pc,
                                                input logic [ADDR_WIDTH-1:0] nxt);
        logic [SLOT_W-1:0] slot;
        logic              taken, hit, lp, gp, tp, pred;
        outcome_t          res;
        slot  = pc[SLOT_W-1:0];
        taken = (nxt != pc + ADDR_WIDTH'(4));
        hit   = (tag_mirror[slot] == pc);
        lp    = hit && (local_mirror[slot] >= CTR_WEAK_T);
        gp    = (global_mirror >= CTR_WEAK_T);
        tp    = (lp == gp) ? lp : ((chooser_mirror < CTR_WEAK_T) ? lp : gp);
        case (mode_mirror)
            MODE_LOCAL:  pred = lp;
            MODE_GLOBAL: pred = gp;
            default:     pred = tp;
        endcase
        if (!hit) begin
            tag_mirror[slot]   = pc;
            local_mirror[slot] = taken ? CTR_WEAK_T : CTR_WEAK_N;
        end else begin
            local_mirror[slot] = nudge(local_mirror[slot], taken);
        end
        global_mirror = nudge(global_mirror, taken);
        if (lp != gp) begin
            chooser_mirror = nudge(chooser_mirror, gp == taken);
        end
        res.predicted = pred;
        res.actual    = taken;
        res.correct   = (pred == taken);
        return res;
    endfunction

    task automatic compare_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        outcome_t want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                tag_mirror[s]   = '0;
                local_mirror[s] = CTR_MIN;
            end
            global_mirror  = CTR_MIN;
            chooser_mirror = CTR_MIN;
            mode_mirror    = MODE_TOURN;
            outcome_q.delete();
        end else begin
            if (i_result_valid) begin
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, expected nothing, actual %b%b%b",
                             $time, i_predicted_taken, i_actual_taken, i_prediction_correct);
                end else begin
                    want = outcome_q.pop_front();
                    compare_field("predicted_taken", want.predicted, i_predicted_taken);
                    compare_field("actual_taken", want.actual, i_actual_taken);
                    compare_field("prediction_correct", want.correct, i_prediction_correct);
                end
            end
            if (i_cfg_wr_en) begin
                mode_mirror = i_cfg_wr_data;
            end
            if (i_start && !i_busy) begin
                outcome_q.push_back(resolve_branch(i_branch_pc, i_next_pc));
            end
        end
        o_pending <= outcome_q.size();
        o_errors  <= mismatches;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// request stimulus and verdict for the tournament branch predictor
// ----------------------------------------------------------------------------
// a directed burst covers the reset tags, address wrap, slot aliasing and
// counter saturation; then seven phases of random branches run under every
// predictor_mode value, including the spare code. most random requests come
// from a small pool of branches with a fixed taken bias, so tables, global
// counter and chooser all train; the rest alias pool slots or are pure noise.
// ----------------------------------------------------------------------------
module tb;
    import tbp_pkg::*;

    localparam logic [1:0] MODE_SPARE       = 2'd3;   // unused code, acts as tournament
    localparam int         RANDOM_PER_PHASE = 270;
    localparam int         PHASES           = 7;
    localparam int         POOL_SIZE        = 32;
    localparam int         CYCLE_LIMIT      = 100000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic [ADDR_WIDTH-1:0] branch_pc   = '0;
    logic [ADDR_WIDTH-1:0] next_pc     = '0;
    logic                  cfg_wr_en   = 1'b0;
    logic [1:0]            cfg_wr_data = MODE_TOURN;
    logic                  busy;
    logic                  result_valid;
    logic                  predicted_taken;
    logic                  actual_taken;
    logic                  prediction_correct;
    int                    pending;
    int                    errors;
    int                    cycles      = 0;
    logic                  steady      = 1'b0;      // no gaps between requests

    // pool of recurring branches: address, taken target and taken odds in percent
    logic [ADDR_WIDTH-1:0] pool_pc     [POOL_SIZE];
    logic [ADDR_WIDTH-1:0] pool_target [POOL_SIZE];
    int                    pool_bias   [POOL_SIZE];

    always #4 clk = ~clk;

    tournament_branch_predictor dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .start                (start),
        .busy                 (busy),
        .i_branch_pc          (branch_pc),
        .i_next_pc            (next_pc),
        .i_cfg_wr_en          (cfg_wr_en),
        .i_cfg_wr_data        (cfg_wr_data),
        .o_result_valid       (result_valid),
        .o_predicted_taken    (predicted_taken),
        .o_actual_taken       (actual_taken),
        .o_prediction_correct (prediction_correct)
    );

    tbp_outcome_checker u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_start              (start),
        .i_busy               (busy),
        .i_branch_pc          (branch_pc),
        .i_next_pc            (next_pc),
        .i_cfg_wr_en          (cfg_wr_en),
        .i_cfg_wr_data        (cfg_wr_data),
        .i_result_valid       (result_valid),
        .i_predicted_taken    (predicted_taken),
        .i_actual_taken       (actual_taken),
        .i_prediction_correct (prediction_correct),
        .o_pending            (pending),
        .o_errors             (errors)
    );

    // watchdog, covers the table sweep after reset and every request gap
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // present one request and hold it until the block takes it; start stays
    // high into the next request unless a gap is drawn
    task automatic send_branch(input logic [ADDR_WIDTH-1:0] pc,
                               input logic [ADDR_WIDTH-1:0] nxt);
        start     <= 1'b1;
        branch_pc <= pc;
        next_pc   <= nxt;
        do @(posedge clk); while (busy !== 1'b0);
        if (!steady && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    // mode changes only once every result is back
    task automatic set_mode(input logic [1:0] m);
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // fresh pool per phase; a few entries sit on awkward addresses
    task automatic refill_pool();
        int odds;
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_pc[k] = {$urandom, $urandom};
            odds = $urandom_range(0, 4);
            case (odds)
                0:       pool_bias[k] = 3;
                1:       pool_bias[k] = 20;
                2:       pool_bias[k] = 50;
                3:       pool_bias[k] = 80;
                default: pool_bias[k] = 97;
            endcase
            // short hop as a compressed branch would make, or a far jump
            pool_target[k] = $urandom_range(0, 1) ? pool_pc[k] + 64'd2 : {$urandom, $urandom};
        end
        pool_pc[0] = 64'hFFFF_FFFF_FFFF_FFFC;                  // fall-through wraps to zero
        pool_pc[1] = {pool_pc[1][ADDR_WIDTH-1:SLOT_W], pool_pc[2][SLOT_W-1:0]};  // thrash a slot
        pool_pc[3] = ADDR_WIDTH'($urandom_range(0, 3) << 2);                     // low addresses
    endtask

    function automatic void make_branch(output logic [ADDR_WIDTH-1:0] pc,
                                        output logic [ADDR_WIDTH-1:0] nxt);
        int                    pick;
        int                    k;
        logic [ADDR_WIDTH-1:0] noise;
        noise = {$urandom, $urandom};
        pick  = $urandom_range(0, 99);
        k     = $urandom_range(0, POOL_SIZE - 1);
        if (pick < 75) begin
            // recurring branch, taken with its own odds
            pc  = pool_pc[k];
            nxt = ($urandom_range(0, 99) < pool_bias[k]) ? pool_target[k] : pc + 64'd4;
        end else if (pick < 85) begin
            // same slot as a pool branch, other tag
            pc  = {noise[ADDR_WIDTH-1:SLOT_W], pool_pc[k][SLOT_W-1:0]};
            nxt = $urandom_range(0, 1) ? pc + 64'd4 : pool_target[k];
        end else begin
            // pure noise
            pc  = noise;
            nxt = $urandom_range(0, 1) ? pc + 64'd4 : {$urandom, $urandom};
        end
    endfunction

    initial begin
        logic [ADDR_WIDTH-1:0] pc;
        logic [ADDR_WIDTH-1:0] nxt;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset tag of slot 0 matches address zero, counter starts at zero
        send_branch(64'h0, 64'h4);
        send_branch(64'h0, 64'h0);
        send_branch(64'h0, 64'h8);
        send_branch(64'h0, 64'h8);
        send_branch(64'h0, 64'h8);                               // saturates high
        send_branch(64'h0, 64'h4);
        // alias of slot 0 with another tag: retag, then hit
        send_branch(64'(SLOTS), 64'(SLOTS) + 64'h4);
        send_branch(64'(SLOTS), 64'h0);
        // fall-through wraps past the top of the address space
        send_branch('1, 64'h3);
        send_branch('1, 64'h0);
        send_branch('1, '1);
        send_branch(64'hFFFF_FFFF_FFFF_FFFC, 64'h0);
        send_branch(64'hFFFF_FFFF_FFFF_FFFC, 64'hFFFF_FFFF_FFFF_FFFE);
        send_branch(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_branch(64'h5555_5555_5555_5554, 64'h5555_5555_5555_5558);
        send_branch(64'hAAAA_AAAA_AAAA_AAA8, 64'hAAAA_AAAA_AAAA_AAAA);
        // global counter high, new branches not taken: local and global disagree
        send_branch(64'h0000_0000_0000_1000, 64'h0000_0000_0000_1004);
        send_branch(64'h0000_0000_0000_2000, 64'h0000_0000_0000_2004);
        send_branch(64'h0000_0000_0000_3000, 64'h0000_0000_0000_3004);
        // and the opposite way round with global low
        send_branch(64'h0000_0000_0000_1000, 64'h0000_0000_0000_0F00);
        send_branch(64'h0000_0000_0000_1000, 64'h0000_0000_0000_0F00);
        send_branch(64'h0000_0000_0000_1000, 64'h0000_0000_0000_0F00);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       ;                                       // reset mode, tournament
                1:       set_mode(MODE_LOCAL);
                2:       set_mode(MODE_GLOBAL);
                3:       set_mode(MODE_SPARE);
                4:       set_mode(MODE_TOURN);
                5:       set_mode(MODE_LOCAL);
                default: set_mode(MODE_GLOBAL);
            endcase
            steady = (p == 3);                                   // back-to-back phase
            refill_pool();
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                make_branch(pc, nxt);
                send_branch(pc, nxt);
            end
        end

        // drain, then allow the pipeline latency
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
